[hw/rtl/flash_ring_log_pointer_manager_core_assert.svh]
// ----------------------------------------------------------------------------
// flash_ring_log_pointer_manager_core_assert.svh
// Assertion macros for the flash ring log pointer manager.
// ----------------------------------------------------------------------------
`ifndef FLASH_RING_LOG_POINTER_MANAGER_CORE_ASSERT_SVH
`define FLASH_RING_LOG_POINTER_MANAGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FRLPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FRLPM_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define FRLPM_ASSERT(lbl, clk, rstn, prop, msg)
`define FRLPM_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[hw/rtl/frlpm_pkg.sv]
// ----------------------------------------------------------------------------
// frlpm_pkg
// Shared constants, codes and types of the flash ring log pointer manager.
// ----------------------------------------------------------------------------
package frlpm_pkg;

  localparam int REGION_BYTES      = 32768;
  localparam int ERASE_BLOCK_BYTES = 4096;
  localparam int BLK_LOG           = $clog2(ERASE_BLOCK_BYTES);

  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 16;
  localparam int OFS_W   = 16;
  localparam int EXT_W   = 18;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int OP_W    = 3;
  localparam int ST_W    = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

  localparam logic [OP_W-1:0] OP_ERASE   = 3'd0;
  localparam logic [OP_W-1:0] OP_PROGRAM = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_SAVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_DONE    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_ROOM = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [ST_W-1:0] ST_HIT     = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              len_zero;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  bo;
    logic [ST_W-1:0]   st;
    logic [LEN_W-1:0]  acc;
    logic              last;
  } item_t;

endpackage

[hw/rtl/frlpm_front.sv]
// ----------------------------------------------------------------------------
// frlpm_front
// Request intake: registers a request and classifies it into a command.
// ----------------------------------------------------------------------------
module frlpm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [frlpm_pkg::IN_TDATA_W-1:0]  in_tdata,   // request_length
  input  logic [frlpm_pkg::CMD_W-1:0]       in_tuser,   // command
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output frlpm_pkg::cmd_t                   cmd
);
  import frlpm_pkg::*;

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_r, hold_nxt;
  logic [KIND_W-1:0] kind;

  always_comb begin
    unique case (in_tuser)
      CMD_APPEND: kind = KIND_APPEND;
      CMD_FETCH:  kind = KIND_FETCH;
      CMD_CLEAR:  kind = KIND_CLEAR;
      default:    kind = KIND_NOP;
    endcase
  end

  assign in_tready = !hold_valid_r || cmd_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (in_tvalid && in_tready) begin
      hold_valid_nxt    = 1'b1;
      hold_nxt.kind     = kind;
      hold_nxt.len      = in_tdata[LEN_W-1:0];
      hold_nxt.len_zero = (in_tdata[LEN_W-1:0] == '0);
    end else if (cmd_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign cmd_valid = hold_valid_r;
  assign cmd       = hold_r;

endmodule

[hw/rtl/frlpm_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// frlpm_cmd_fifo
// Short command queue between intake and sequencer.
// ----------------------------------------------------------------------------
module frlpm_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  frlpm_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop,
  output frlpm_pkg::cmd_t pop_cmd
);
  import frlpm_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/frlpm_back.sv]
// ----------------------------------------------------------------------------
// frlpm_back
// Sequencer: keeps the offsets and emits the flash operation items.
// ----------------------------------------------------------------------------
`include "flash_ring_log_pointer_manager_core_assert.svh"

module frlpm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [frlpm_pkg::ADDR_W-1:0]  cfg_wr_data,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  frlpm_pkg::cmd_t               cmd,
  output logic                          item_valid,
  input  logic                          item_ready,
  output frlpm_pkg::item_t              item
);
  import frlpm_pkg::*;

  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_A_CHK = 4'd1;
  localparam logic [SW-1:0] S_SEG_A = 4'd2;
  localparam logic [SW-1:0] S_SEG_E = 4'd3;
  localparam logic [SW-1:0] S_SEG_P = 4'd4;
  localparam logic [SW-1:0] S_F_CHK = 4'd5;
  localparam logic [SW-1:0] S_F_RD1 = 4'd6;
  localparam logic [SW-1:0] S_F_RD2 = 4'd7;
  localparam logic [SW-1:0] S_SAVE  = 4'd8;
  localparam logic [SW-1:0] S_DONE  = 4'd9;

  localparam logic [EXT_W-1:0] R_X     = EXT_W'(REGION_BYTES);
  localparam logic [EXT_W-1:0] BS_X    = EXT_W'(ERASE_BLOCK_BYTES);
  localparam logic [EXT_W-1:0] BS_MASK = EXT_W'(ERASE_BLOCK_BYTES - 1);

  logic [ADDR_W-1:0] base_r;
  logic [SW-1:0]     state_r, state_nxt;
  logic [OFS_W-1:0]  wo_r, wo_nxt, ro_r, ro_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, seg_r, seg_nxt, bo_r, bo_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt, part_r, part_nxt, acc_r, acc_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic              split_r, split_nxt, second_r, second_nxt;
  logic              fit_r, fit_nxt, aligned_r, aligned_nxt;
  logic [EXT_W-1:0]  ea_r, ea_nxt, es_r, es_nxt;
  logic              out_valid_r, out_valid_nxt;
  item_t             out_r;

  logic              can_load, em_valid;
  item_t             em;
  logic [EXT_W-1:0]  em_off;

  logic [EXT_W-1:0]  wo_x, ro_x, len_x, seg_x, n_x, part_x;
  logic [EXT_W-1:0]  free_x, low_x, room_x, nb_x, es_c, fe_x, wsum_x, avail_x, rpart_x;
  logic [EXT_W-1:0]  rsum_x, fn_x;
  logic              no_room, fit_all, hit, direct;

  assign can_load = !out_valid_r || item_ready;

  assign wo_x   = EXT_W'(wo_r);
  assign ro_x   = EXT_W'(ro_r);
  assign len_x  = EXT_W'(len_r);
  assign seg_x  = EXT_W'(seg_r);
  assign n_x    = EXT_W'(n_r);
  assign part_x = EXT_W'(part_r);

  always_comb begin
    if (wo_r == ro_r) begin
      free_x = R_X;
    end else if (ro_r < wo_r) begin
      free_x = R_X - (wo_x - ro_x);
    end else begin
      free_x = ro_x - wo_x;
    end
  end
  assign no_room = (free_x < BS_X) || (len_x > free_x - BS_X);
  assign fit_all = (wo_x + len_x) <= R_X;

  assign low_x  = wo_x & BS_MASK;
  assign room_x = BS_X - low_x;
  assign nb_x   = ((seg_x - room_x) >> BLK_LOG) + EXT_W'(1);

  always_comb begin
    if (ea_r >= R_X) begin
      es_c = '0;
    end else if (ea_r + es_r > R_X) begin
      es_c = R_X - ea_r;
    end else begin
      es_c = es_r;
    end
  end
  assign hit    = (es_c == '0) || ((ro_x > ea_r) && (ro_x <= ea_r + es_c - EXT_W'(1)));
  assign fe_x   = (wo_x + BS_X > R_X) ? R_X - wo_x : BS_X;
  assign wsum_x = wo_x + seg_x;

  assign avail_x = (ro_r < wo_r) ? wo_x - ro_x : R_X - (ro_x - wo_x);
  assign fn_x    = (avail_x > len_x) ? len_x : avail_x;
  assign rpart_x = R_X - ro_x;
  assign direct  = (ro_r < wo_r) || (rpart_x > n_x);
  assign rsum_x  = ro_x + n_x;

  always_comb begin
    state_nxt   = state_r;
    wo_nxt      = wo_r;
    ro_nxt      = ro_r;
    len_nxt     = len_r;
    seg_nxt     = seg_r;
    bo_nxt      = bo_r;
    n_nxt       = n_r;
    part_nxt    = part_r;
    acc_nxt     = acc_r;
    st_nxt      = st_r;
    split_nxt   = split_r;
    second_nxt  = second_r;
    fit_nxt     = fit_r;
    aligned_nxt = aligned_r;
    ea_nxt      = ea_r;
    es_nxt      = es_r;
    cmd_pop     = 1'b0;
    em_valid    = 1'b0;
    em          = '0;
    em_off      = '0;
    if (can_load) begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_pop = 1'b1;
            len_nxt = cmd.len;
            st_nxt  = ST_OK;
            acc_nxt = '0;
            unique case (cmd.kind)
              KIND_APPEND: state_nxt = cmd.len_zero ? S_DONE : S_A_CHK;
              KIND_FETCH:  state_nxt = cmd.len_zero ? S_DONE : S_F_CHK;
              KIND_CLEAR: begin
                wo_nxt    = '0;
                ro_nxt    = '0;
                state_nxt = S_SAVE;
              end
              default:     state_nxt = S_DONE;
            endcase
            if ((cmd.kind == KIND_APPEND || cmd.kind == KIND_FETCH) && cmd.len_zero) begin
              st_nxt = ST_ZERO;
            end
          end
        end
        S_A_CHK: begin
          if (no_room) begin
            st_nxt    = ST_NO_ROOM;
            state_nxt = S_DONE;
          end else begin
            seg_nxt    = fit_all ? len_r : LEN_W'(R_X - wo_x);
            split_nxt  = !fit_all;
            second_nxt = 1'b0;
            bo_nxt     = '0;
            state_nxt  = S_SEG_A;
          end
        end
        S_SEG_A: begin
          aligned_nxt = (low_x == '0);
          fit_nxt     = (seg_x <= room_x);
          if (low_x == '0) begin
            ea_nxt = wo_x;
            es_nxt = (nb_x + EXT_W'(1)) << BLK_LOG;
          end else begin
            ea_nxt = (wo_x & ~BS_MASK) + BS_X;
            es_nxt = nb_x << BLK_LOG;
          end
          state_nxt = S_SEG_E;
        end
        S_SEG_E: begin
          if (fit_r) begin
            if (aligned_r) begin
              em_valid = 1'b1;
              em.op    = OP_ERASE;
              em_off   = wo_x;
              em.len   = LEN_W'(fe_x);
            end
            state_nxt = S_SEG_P;
          end else if (hit) begin
            st_nxt = ST_HIT;
            if (second_r) begin
              acc_nxt   = bo_r;
              state_nxt = S_SAVE;
            end else begin
              acc_nxt   = '0;
              state_nxt = S_DONE;
            end
          end else begin
            em_valid  = 1'b1;
            em.op     = OP_ERASE;
            em_off    = ea_r;
            em.len    = LEN_W'(es_c);
            state_nxt = S_SEG_P;
          end
        end
        S_SEG_P: begin
          em_valid = 1'b1;
          em.op    = OP_PROGRAM;
          em_off   = wo_x;
          em.len   = seg_r;
          em.bo    = bo_r;
          wo_nxt   = (wsum_x >= R_X) ? '0 : OFS_W'(wsum_x);
          if (split_r && !second_r) begin
            second_nxt = 1'b1;
            wo_nxt     = '0;
            bo_nxt     = seg_r;
            seg_nxt    = len_r - seg_r;
            state_nxt  = S_SEG_A;
          end else begin
            st_nxt    = ST_OK;
            acc_nxt   = len_r;
            state_nxt = S_SAVE;
          end
        end
        S_F_CHK: begin
          if (ro_r == wo_r) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            n_nxt     = LEN_W'(fn_x);
            state_nxt = S_F_RD1;
          end
        end
        S_F_RD1: begin
          em_valid = 1'b1;
          em.op    = OP_READ;
          em_off   = ro_x;
          st_nxt   = ST_OK;
          acc_nxt  = n_r;
          if (direct) begin
            em.len    = n_r;
            ro_nxt    = (rsum_x >= R_X) ? '0 : OFS_W'(rsum_x);
            state_nxt = S_SAVE;
          end else begin
            em.len   = LEN_W'(rpart_x);
            part_nxt = LEN_W'(rpart_x);
            ro_nxt   = '0;
            state_nxt = (n_x > rpart_x) ? S_F_RD2 : S_SAVE;
          end
        end
        S_F_RD2: begin
          em_valid  = 1'b1;
          em.op     = OP_READ;
          em_off    = '0;
          em.len    = LEN_W'(n_x - part_x);
          em.bo     = part_r;
          ro_nxt    = OFS_W'(n_x - part_x);
          state_nxt = S_SAVE;
        end
        S_SAVE: begin
          em_valid  = 1'b1;
          em.op     = OP_SAVE;
          state_nxt = S_DONE;
        end
        S_DONE: begin
          em_valid  = 1'b1;
          em.op     = OP_DONE;
          em.st     = st_r;
          em.acc    = acc_r;
          em.last   = 1'b1;
          state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
    if (em.op == OP_ERASE || em.op == OP_PROGRAM || em.op == OP_READ) begin
      em.addr = base_r + ADDR_W'(em_off);
    end
  end

  always_comb begin
    if (can_load) begin
      out_valid_nxt = em_valid;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wo_r        <= '0;
      ro_r        <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wo_r        <= wo_nxt;
      ro_r        <= ro_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    seg_r     <= seg_nxt;
    bo_r      <= bo_nxt;
    n_r       <= n_nxt;
    part_r    <= part_nxt;
    acc_r     <= acc_nxt;
    st_r      <= st_nxt;
    split_r   <= split_nxt;
    second_r  <= second_nxt;
    fit_r     <= fit_nxt;
    aligned_r <= aligned_nxt;
    ea_r      <= ea_nxt;
    es_r      <= es_nxt;
    if (can_load && em_valid) begin
      out_r <= em;
    end
  end

  assign item_valid = out_valid_r;
  assign item       = out_r;

  `FRLPM_ASSERT(a_wo_range, clk, rst_n, wo_r < OFS_W'(REGION_BYTES), "write offset out of region")
  `FRLPM_ASSERT(a_ro_range, clk, rst_n, ro_r < OFS_W'(REGION_BYTES), "read offset out of region")
  `FRLPM_ASSERT(a_last_done, clk, rst_n, out_valid_r |-> (out_r.last == (out_r.op == OP_DONE)), "last not on done item")
  `FRLPM_ASSERT(a_done_idle, clk, rst_n, (state_r == S_DONE && can_load) |=> (state_r == S_IDLE), "done did not return to idle")
  `FRLPM_NEVER(a_pop_busy, clk, rst_n, cmd_pop && (state_r != S_IDLE), "command taken while busy")

endmodule

[hw/rtl/flash_ring_log_pointer_manager_core.sv]
// ----------------------------------------------------------------------------
// flash_ring_log_pointer_manager_core
// Circular flash log offset manager: turns append, fetch and clear requests
// into runs of erase, program, read, save and done items.
// ----------------------------------------------------------------------------
// channel  dir  tdata                     tuser       tlast
// in_      in   request_length            command     -
// out_     out  address/len/bo/st/acc     operation   last item of run
// cfg_     in   region_base (write only)  -           -
//
// One request at a time; the sequencer steps one state per cycle while the
// output register can load, and each run ends in a done item.
// At most one result item leaves per cycle through the output register.
// A two-entry command queue lets new requests enter while a run is active.
// Output stalls freeze the sequencer; reset clears offsets and region base.
// ----------------------------------------------------------------------------
module flash_ring_log_pointer_manager_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [frlpm_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] request_length
  input  logic [frlpm_pkg::CMD_W-1:0]        in_tuser,   // [1:0] command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [23:0] flash_address, [39:24] operation_length, [55:40] buffer_offset,
  // [58:56] status, [74:59] accepted_length, [79:75] zero
  output logic [frlpm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [frlpm_pkg::OP_W-1:0]         out_tuser,  // [2:0] operation
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [frlpm_pkg::ADDR_W-1:0]       cfg_wr_data
);
  import frlpm_pkg::*;

  logic  f_valid, f_ready, q_valid, q_pop;
  cmd_t  f_cmd, q_cmd;
  item_t item;

  frlpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  frlpm_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  frlpm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd         (q_cmd),
    .item_valid  (out_tvalid),
    .item_ready  (out_tready),
    .item        (item)
  );

  assign out_tdata = {5'd0, item.acc, item.st, item.bo, item.len, item.addr};
  assign out_tuser = item.op;
  assign out_tlast = item.last;

endmodule
